/* design/idl_pkg.sv */
// Shared constants and types for the id list block.
package idl_pkg;

    localparam int DEPTH_DEF   = 64;
    localparam int ID_BITS_DEF = 16;

    localparam int COUNT_BITS  = 7;
    localparam int STATUS_BITS = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_REMOVED   = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd3;

    // Operation broadcast to every cell, already qualified by the handshake.
    typedef struct packed {
        logic ins;
        logic rem;
    } idl_op_t;

endpackage

/* design/idl_cell.sv */
// One list slot: holds an id and its valid bit, compares and shifts from its neighbor.
module idl_cell import idl_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  idl_op_t            op,
    input  logic [ID_BITS-1:0] id,
    input  logic               prev_valid,
    input  logic               next_valid,
    input  logic [ID_BITS-1:0] next_entry,
    input  logic               shift,
    output logic               valid,
    output logic [ID_BITS-1:0] entry,
    output logic               match
);

    logic               valid_reg;
    logic               valid_next;
    logic [ID_BITS-1:0] entry_reg;
    logic [ID_BITS-1:0] entry_next;

    assign valid = valid_reg;
    assign entry = entry_reg;
    assign match = valid_reg && (entry_reg == id);

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        // tail slot is the first empty cell: the head cell, or one right after a filled cell
        if (op.ins && !valid_reg && prev_valid)
        begin
            valid_next = 1'b1;
            entry_next = id;
        end
        else if (op.rem && shift)
        begin
            valid_next = next_valid;
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* design/idl_prefix.sv */
// Log-depth inclusive prefix OR over the cell match bits.
module idl_prefix import idl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic [DEPTH-1:0] match,
    output logic [DEPTH-1:0] prefix
);

    localparam int LEVELS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [LEVELS:0][DEPTH-1:0] lvl;

    assign lvl[0] = match;

    for (genvar l = 0; l < LEVELS; l++)
    begin : g_lvl
        localparam int STRIDE = 1 << l;
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_bit
            if (i >= STRIDE)
            begin : g_or
                assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-STRIDE];
            end
            else
            begin : g_pass
                assign lvl[l+1][i] = lvl[l][i];
            end
        end
    end

    assign prefix = lvl[LEVELS];

endmodule

/* design/id_list_insert_remove.sv */
// Top level: ordered id list built as a chain of cells, insert at tail, remove first match.
//
//  channel | dir | handshake            | fields
//  --------+-----+----------------------+------------------------------
//  req     | in  | req_valid/req_ready  | command[0:0], id[ID_BITS-1:0]
//  rsp     | out | rsp_valid/rsp_ready  | status[1:0], count[6:0]
//
// One word per cycle: every cell compares its id in parallel, a log-depth prefix OR
// picks the first match, and all cells load or shift in the same cycle.
// The result sits in an output register; a new word is taken whenever that register
// is empty or being drained, so rsp_ready low stalls req_ready.
// Reset clears valid bits, count_reg and rsp_valid; ids, status and count are not reset.
module id_list_insert_remove import idl_pkg::*;
#(
    parameter int DEPTH   = DEPTH_DEF,
    parameter int ID_BITS = ID_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  logic                   command,
    input  logic [ID_BITS-1:0]     id,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output logic [STATUS_BITS-1:0] status,
    output logic [COUNT_BITS-1:0]  count
);

    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic                   fire;
    idl_op_t                op;
    logic [DEPTH-1:0]       valid_vec;
    logic [DEPTH-1:0]       match_vec;
    logic [DEPTH-1:0]       shift_vec;
    logic [ID_BITS-1:0]     entry_arr [DEPTH];
    logic                   full;
    logic                   found;

    logic [CNT_BITS-1:0]    count_reg;
    logic [CNT_BITS-1:0]    count_next;
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    logic [STATUS_BITS-1:0] status_reg;
    logic [STATUS_BITS-1:0] status_next;
    logic [COUNT_BITS-1:0]  rsp_count_reg;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign fire      = req_valid && req_ready;
    assign op.ins    = fire && (command == CMD_INSERT);
    assign op.rem    = fire && (command == CMD_REMOVE);

    assign full  = valid_vec[DEPTH-1];
    assign found = shift_vec[DEPTH-1];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic               prev_v;
        logic               next_v;
        logic [ID_BITS-1:0] next_e;

        if (i == 0)
        begin : g_head
            assign prev_v = 1'b1;
        end
        else
        begin : g_mid
            assign prev_v = valid_vec[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_v = 1'b0;
            assign next_e = '0;
        end
        else
        begin : g_body
            assign next_v = valid_vec[i+1];
            assign next_e = entry_arr[i+1];
        end

        idl_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (op),
            .id         (id),
            .prev_valid (prev_v),
            .next_valid (next_v),
            .next_entry (next_e),
            .shift      (shift_vec[i]),
            .valid      (valid_vec[i]),
            .entry      (entry_arr[i]),
            .match      (match_vec[i])
        );
    end

    idl_prefix #(
        .DEPTH (DEPTH)
    ) u_prefix (
        .match  (match_vec),
        .prefix (shift_vec)
    );

    always_comb
    begin
        count_next     = count_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (op.ins)
        begin
            rsp_valid_next = 1'b1;
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_INSERTED;
                count_next  = count_reg + CNT_BITS'(1);
            end
        end
        else if (op.rem)
        begin
            rsp_valid_next = 1'b1;
            if (found)
            begin
                status_next = ST_REMOVED;
                count_next  = count_reg - CNT_BITS'(1);
            end
            else
            begin
                status_next = ST_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg    <= status_next;
            rsp_count_reg <= COUNT_BITS'(count_next);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign count     = rsp_count_reg;

`ifndef SYNTHESIS
    localparam int VW = DEPTH + 1;

    // count tracks the number of occupied cells
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("count does not match occupied cells");

    // occupied cells always form a contiguous run from the head
    assert property (@(posedge clk) disable iff (!rst_n)
        (((VW'(valid_vec)) + VW'(1)) & VW'(valid_vec)) == '0)
        else $error("occupied cells not contiguous");

    // a dropped insert is only reported with the list full
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (command == CMD_INSERT) && !full) |=> (status_reg == ST_INSERTED))
        else $error("insert with room not reported as inserted");

    // a removal takes exactly one cell out
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (command == CMD_REMOVE) && found)
            |=> ($countones(valid_vec) + 1 == $countones($past(valid_vec))))
        else $error("remove did not free exactly one cell");
`endif

endmodule
